@@ hdl/multitouch_slot_tracker_unit_macros.svh @@
// Assertion macros shared by the slot tracker modules.
`ifndef MULTITOUCH_SLOT_TRACKER_UNIT_MACROS_SVH
`define MULTITOUCH_SLOT_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define MST_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: name");

// Next-cycle implication.
`define MST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: name");

`else

`define MST_ASSERT_IMP(name, clk, rst, ante, cons)
`define MST_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ hdl/mst_pkg.sv @@
package mst_pkg;

   // Request codes
   localparam logic [1:0] REQ_DOWN   = 2'd0;
   localparam logic [1:0] REQ_UP     = 2'd1;
   localparam logic [1:0] REQ_MOTION = 2'd2;

   // Event codes; also the bit positions in a run mask
   typedef enum logic [2:0] {
      EV_SLOT  = 3'd0,
      EV_TRACK = 3'd1,
      EV_POSX  = 3'd2,
      EV_POSY  = 3'd3,
      EV_SYNC  = 3'd4
   } event_code_type;

   localparam int NUM_EVENTS = 5;

   // Slot numbers travel at the width of the largest table
   localparam int SLOT_FIELD_W = 5;

   localparam logic [5:0]  SLOT_NONE     = 6'd63;
   localparam logic [15:0] TRACK_RELEASE = 16'hFFFF;

   typedef struct packed {
      logic                    free_hit;
      logic [SLOT_FIELD_W-1:0] free_slot;
      logic                    own_hit;
      logic [SLOT_FIELD_W-1:0] own_slot;
   } lookup_type;

   typedef struct packed {
      logic                    set_busy;
      logic                    clr_busy;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [15:0]             owner_id;
   } table_wr_type;

   typedef struct packed {
      logic [NUM_EVENTS-1:0]   mask;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [15:0]             track;
      logic [15:0]             pos_x;
      logic [15:0]             pos_y;
   } run_type;

endpackage

@@ hdl/mst_slot_table.sv @@
module mst_slot_table
   import mst_pkg::*;
#(
   parameter int NUM_SLOTS = 10
)(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  touch_id,
   output lookup_type   lookup,
   input  table_wr_type wr
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [NUM_SLOTS-1:0] busy_ff;
   logic [NUM_SLOTS-1:0] busy_in;
   logic [15:0]          owner_ff [NUM_SLOTS];

   // Lowest free slot and lowest busy slot owned by the finger
   always_comb begin
      lookup = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!busy_ff[i] && !lookup.free_hit) begin
            lookup.free_hit  = 1'b1;
            lookup.free_slot = SLOT_FIELD_W'(i);
         end
         if (busy_ff[i] && (owner_ff[i] == touch_id) && !lookup.own_hit) begin
            lookup.own_hit  = 1'b1;
            lookup.own_slot = SLOT_FIELD_W'(i);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (wr.set_busy) begin
         busy_in[wr.slot[SLOT_W-1:0]] = 1'b1;
      end
      if (wr.clr_busy) begin
         busy_in[wr.slot[SLOT_W-1:0]] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.set_busy) begin
         owner_ff[wr.slot[SLOT_W-1:0]] <= wr.owner_id;
      end
   end

endmodule

@@ hdl/mst_event_seq.sv @@
`include "multitouch_slot_tracker_unit_macros.svh"

module mst_event_seq
   import mst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  run_type            run,
   output logic               run_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_code,
   output logic signed [15:0] rsp_event_value,
   output logic               rsp_last
);

   logic [NUM_EVENTS-1:0] mask_ff;
   logic [NUM_EVENTS-1:0] mask_in;
   logic [NUM_EVENTS-1:0] low_bit;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [15:0]           track_ff;
   logic [15:0]           pos_x_ff;
   logic [15:0]           pos_y_ff;
   event_code_type        sel;
   logic                  found;
   logic                  take;

   // Lowest pending event goes out first
   always_comb begin
      sel   = EV_SYNC;
      found = 1'b0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         if (mask_ff[i] && !found) begin
            found = 1'b1;
            sel   = event_code_type'(i[2:0]);
         end
      end
   end

   assign low_bit   = mask_ff & (~mask_ff + NUM_EVENTS'(1));
   assign rsp_valid = |mask_ff;
   assign rsp_last  = (sel == EV_SYNC);
   assign take      = rsp_valid && rsp_ready;
   assign run_free  = !rsp_valid || (take && rsp_last);

   assign rsp_event_code = sel;

   always_comb begin
      case (sel)
         EV_SLOT:  rsp_event_value = 16'(slot_ff);
         EV_TRACK: rsp_event_value = track_ff;
         EV_POSX:  rsp_event_value = pos_x_ff;
         EV_POSY:  rsp_event_value = pos_y_ff;
         default:  rsp_event_value = 16'sd0;
      endcase
   end

   always_comb begin
      mask_in = mask_ff;
      if (take) begin
         mask_in = mask_ff & ~low_bit;
      end
      if (load) begin
         mask_in = run.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff  <= run.slot;
         track_ff <= run.track;
         pos_x_ff <= run.pos_x;
         pos_y_ff <= run.pos_y;
      end
   end

   // A pending run always ends with its sync report
   `MST_ASSERT_IMP(a_run_has_sync, clock, reset, |mask_ff, mask_ff[EV_SYNC])
   `MST_ASSERT_IMP(a_load_when_free, clock, reset, load, run_free)
   `MST_ASSERT_NEXT(a_run_continues, clock, reset, take && !rsp_last, rsp_valid)

endmodule

@@ hdl/multitouch_slot_tracker_unit.sv @@
// Multitouch slot tracker (type B slot protocol). Each request (finger down,
// up or motion) is registered, looked up against the slot table from that
// register, and turned into a run of events that leave one per cycle on the
// rsp_ port while rsp_ready is high: optional slot select, tracking id, X, Y
// and a closing sync report flagged by rsp_last. A down run holds 5 events at
// most (4 with the slot already announced), motion 3 or 4, up 2 or 3; a
// request that cannot be served (table full, unknown finger, undefined code)
// emits nothing. The single event output port sets the sustained rate; a new
// request is taken while the previous run is still draining and its lookup
// starts in the cycle the last event of that run is delivered.
`include "multitouch_slot_tracker_unit_macros.svh"

module multitouch_slot_tracker_unit
   import mst_pkg::*;
#(
   parameter int NUM_SLOTS      = 10,
   parameter int TRACK_ID_LIMIT = 1023
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_touch_id,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_code,
   output logic signed [15:0] rsp_event_value,
   output logic               rsp_last
);

   // Reciprocal of the id limit: exact quotient for any 16-bit finger id
   localparam logic [32:0] TRACK_RECIP = 33'(((64'd1 << 32) + 64'(TRACK_ID_LIMIT) - 64'd1)
                                             / 64'(TRACK_ID_LIMIT));

   logic         in_valid_ff;
   logic [1:0]   in_type_ff;
   logic [15:0]  in_fid_ff;
   logic [15:0]  in_px_ff;
   logic [15:0]  in_py_ff;
   logic [15:0]  quot_ff;
   logic [48:0]  recip_prod;
   logic [30:0]  quot_mul;
   logic [15:0]  track_val;
   logic [5:0]   announced_ff;
   logic [5:0]   announced_in;
   logic         req_take;
   logic         fire;
   logic         run_free;
   logic         hit;
   logic [SLOT_FIELD_W-1:0] sel_slot;
   lookup_type   lookup;
   table_wr_type wr;
   run_type      run;

   assign req_take   = req_valid && req_ready;
   assign fire       = in_valid_ff && run_free;
   assign req_ready  = !in_valid_ff || fire;
   assign recip_prod = 49'(req_touch_id) * 49'(TRACK_RECIP);
   assign quot_mul   = 31'(quot_ff) * 31'(TRACK_ID_LIMIT);
   assign track_val  = in_fid_ff - quot_mul[15:0] + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_type;
         in_fid_ff  <= req_touch_id;
         in_px_ff   <= req_pos_x;
         in_py_ff   <= req_pos_y;
         quot_ff    <= recip_prod[47:32];
      end
   end

   mst_slot_table #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .touch_id (in_fid_ff),
      .lookup   (lookup),
      .wr       (wr)
   );

   // Build the event run and the table update for the held request
   always_comb begin
      hit      = 1'b0;
      sel_slot = '0;
      run      = '0;
      wr       = '0;
      case (in_type_ff)
         REQ_DOWN: begin
            hit                = lookup.free_hit;
            sel_slot           = lookup.free_slot;
            run.mask[EV_TRACK] = 1'b1;
            run.mask[EV_POSX]  = 1'b1;
            run.mask[EV_POSY]  = 1'b1;
            run.track          = track_val;
            wr.set_busy        = fire && hit;
         end
         REQ_UP: begin
            hit                = lookup.own_hit;
            sel_slot           = lookup.own_slot;
            run.mask[EV_TRACK] = 1'b1;
            run.track          = TRACK_RELEASE;
            wr.clr_busy        = fire && hit;
         end
         REQ_MOTION: begin
            hit               = lookup.own_hit;
            sel_slot          = lookup.own_slot;
            run.mask[EV_POSX] = 1'b1;
            run.mask[EV_POSY] = 1'b1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      run.mask[EV_SYNC] = 1'b1;
      run.mask[EV_SLOT] = (announced_ff != 6'(sel_slot));
      // Drop the whole run when the request cannot be served
      if (!hit) begin
         run.mask = '0;
      end
      run.slot     = sel_slot;
      run.pos_x    = in_px_ff;
      run.pos_y    = in_py_ff;
      wr.slot      = sel_slot;
      wr.owner_id  = in_fid_ff;
   end

   assign announced_in = (fire && hit) ? 6'(sel_slot) : announced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         announced_ff <= SLOT_NONE;
      end else begin
         announced_ff <= announced_in;
      end
   end

   mst_event_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .load            (fire),
      .run             (run),
      .run_free        (run_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last        (rsp_last)
   );

   `MST_ASSERT_IMP(a_ann_range, clock, reset, announced_ff != SLOT_NONE, announced_ff < 6'(NUM_SLOTS))
   `MST_ASSERT_NEXT(a_ann_follows, clock, reset, fire && hit, announced_ff == {1'b0, $past(sel_slot)})
   `MST_ASSERT_NEXT(a_miss_silent, clock, reset, fire && !hit, !rsp_valid)

endmodule

@@ sim/multitouch_slot_tracker_unit_tb.sv @@
module multitouch_slot_tracker_unit_tb;
   import mst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS      = 10;
   localparam int TRACK_ID_LIMIT = 1023;
   localparam int IDLE_LIMIT     = 3000;
   localparam int DRAIN_CYCLES   = 30;
   localparam int RANDOM_ITEMS   = 420;

   // Code the block must ignore
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] fid;
      logic [15:0] x;
      logic [15:0] y;
   } touch_req_type;

   typedef struct {
      event_code_type code;
      logic [15:0]    value;
      logic           last;
   } touch_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = 2'd0;
   logic [15:0]        req_touch_id = 16'd0;
   logic signed [15:0] req_pos_x = 16'sd0;
   logic signed [15:0] req_pos_y = 16'sd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_event_code;
   logic signed [15:0] rsp_event_value;
   logic               rsp_last;

   touch_req_type   touch_requests[$];
   touch_event_type event_queue[$];
   touch_req_type   in_flight;
   int              error_count = 0;

   // Shadow of the slot table
   bit           slot_taken[NUM_SLOTS];
   logic [15:0]  slot_finger[NUM_SLOTS];
   logic [5:0]   shown_slot = SLOT_NONE;

   multitouch_slot_tracker_unit #(
      .NUM_SLOTS      (NUM_SLOTS),
      .TRACK_ID_LIMIT (TRACK_ID_LIMIT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_touch_id    (req_touch_id),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic push_event(input event_code_type code, input logic [15:0] value,
                             input logic last);
      touch_event_type ev;
      ev.code  = code;
      ev.value = value;
      ev.last  = last;
      event_queue.insert(event_queue.size(), ev);
   endtask

   // Update the slot table for one request and queue the events it yields
   task automatic track_touch(input touch_req_type rq);
      int slot;
      slot = -1;
      case (rq.kind)
         REQ_DOWN: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot < 0 && !slot_taken[i]) slot = i;
         end
         REQ_UP, REQ_MOTION: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot < 0 && slot_taken[i] && slot_finger[i] == rq.fid) slot = i;
         end
         default: ;
      endcase
      if (slot < 0) return;
      if (shown_slot != 6'(slot)) begin
         push_event(EV_SLOT, 16'(slot), 1'b0);
         shown_slot = 6'(slot);
      end
      case (rq.kind)
         REQ_DOWN: begin
            slot_taken[slot]  = 1'b1;
            slot_finger[slot] = rq.fid;
            push_event(EV_TRACK, 16'(int'(rq.fid) % TRACK_ID_LIMIT + 1), 1'b0);
            push_event(EV_POSX, rq.x, 1'b0);
            push_event(EV_POSY, rq.y, 1'b0);
         end
         REQ_UP: begin
            push_event(EV_TRACK, TRACK_RELEASE, 1'b0);
            slot_taken[slot] = 1'b0;
         end
         default: begin
            push_event(EV_POSX, rq.x, 1'b0);
            push_event(EV_POSY, rq.y, 1'b0);
         end
      endcase
      push_event(EV_SYNC, 16'd0, 1'b1);
   endtask

   task automatic add_req(input logic [1:0] kind, input logic [15:0] fid,
                          input logic [15:0] x, input logic [15:0] y);
      touch_req_type rq;
      rq.kind = kind;
      rq.fid  = fid;
      rq.x    = x;
      rq.y    = y;
      touch_requests.insert(touch_requests.size(), rq);
   endtask

   // Driver: bursts of requests separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_touch(in_flight);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (touch_requests.size() > 0) begin
               in_flight = touch_requests.pop_front();
               req_type      <= in_flight.kind;
               req_touch_id  <= in_flight.fid;
               req_pos_x     <= in_flight.x;
               req_pos_y     <= in_flight.y;
               req_valid     <= 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0) begin
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 3);
                     2: gap_left = $urandom_range(1, 8);
                     default: gap_left = $urandom_range(5, 20);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switch among always ready, random stalls and a sparse pattern
   int stall_mode  = 0;
   int mode_left   = 0;
   int stall_phase = 0;
   int stall_every = 4;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode  = $urandom_range(0, 2);
            mode_left   = $urandom_range(20, 80);
            stall_every = $urandom_range(2, 7);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (stall_phase % stall_every) == 0;
         endcase
      end
   end

   // Monitor
   always @(posedge clock) begin
      touch_event_type exp_ev;
      if (!reset && rsp_valid && rsp_ready) begin
         if (event_queue.size() == 0) begin
            $error("unexpected event: code %0d value %0d last %0d",
                   rsp_event_code, rsp_event_value, rsp_last);
            error_count++;
         end else begin
            exp_ev = event_queue.pop_front();
            if (rsp_event_code !== exp_ev.code) begin
               $error("event_code: expected %0d, got %0d", exp_ev.code, rsp_event_code);
               error_count++;
            end
            if (rsp_event_value !== exp_ev.value) begin
               $error("event_value: expected %0d, got %0d",
                      $signed(exp_ev.value), rsp_event_value);
               error_count++;
            end
            if (rsp_last !== exp_ev.last) begin
               $error("last: expected %0d, got %0d", exp_ev.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: stop when neither channel moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] pool[16];
      int          r;
      int          pick;

      // Directed part
      add_req(REQ_DOWN, 16'd0, 16'h8000, 16'h7FFF);
      add_req(REQ_MOTION, 16'd0, 16'h7FFF, 16'h8000);      // same slot, no select
      add_req(REQ_DOWN, 16'hFFFF, 16'h0000, 16'h0000);
      add_req(REQ_MOTION, 16'hFFFF, 16'hFFFF, 16'h0001);
      add_req(REQ_MOTION, 16'd0, 16'h1234, 16'hEDCB);      // back to slot 0
      add_req(REQ_UP, 16'hFFFF, 16'($urandom), 16'($urandom));
      add_req(REQ_UP, 16'hFFFF, 16'h5555, 16'hAAAA);       // finger already gone
      add_req(REQ_MOTION, 16'h1234, 16'hAAAA, 16'h5555);   // never touched
      add_req(REQ_UNDEFINED, 16'd0, 16'h7FFF, 16'h7FFF);
      add_req(REQ_DOWN, 16'd0, 16'h0100, 16'h0200);        // second slot for same finger
      for (int i = 0; i < 9; i++)                          // fill table, last one overflows
         add_req(REQ_DOWN, 16'(1000 + i), 16'($urandom), 16'($urandom));
      add_req(REQ_UP, 16'd0, 16'd0, 16'd0);                // lowest of the two slots
      add_req(REQ_MOTION, 16'd0, 16'h0042, 16'hFFC0);
      add_req(REQ_UP, 16'd0, 16'd0, 16'd0);
      add_req(REQ_DOWN, 16'hFFFF, 16'h8000, 16'h8000);

      // Random part over a small pool of fingers so most requests hit
      for (int i = 0; i < 16; i++)
         pool[i] = (i < 9) ? 16'(1000 + i) : 16'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r    = $urandom_range(0, 99);
         pick = $urandom_range(0, 15);
         if ($urandom_range(0, 19) == 0) pool[pick] = 16'($urandom);
         if (r < 30)
            add_req(REQ_DOWN, pool[pick], 16'($urandom), 16'($urandom));
         else if (r < 55)
            add_req(REQ_UP, pool[pick], 16'($urandom), 16'($urandom));
         else if (r < 90)
            add_req(REQ_MOTION, pool[pick], 16'($urandom), 16'($urandom));
         else if (r < 95)
            add_req(REQ_UNDEFINED, pool[pick], 16'($urandom), 16'($urandom));
         else
            add_req(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (touch_requests.size() != 0 || req_valid || event_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (event_queue.size() != 0) begin
         $error("%0d expected events never arrived", event_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
